// ===== rtl/tea_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants, the round mixing function and the round sum functions of the TEA cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned TEA_ROUNDS = 32;
    localparam logic [31:0] TEA_DELTA  = 32'h9E37_79B9;

    localparam int unsigned KEY_IDX_W = 2;

    typedef enum logic [KEY_IDX_W-1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } t_key_idx;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        logic        req_type;
        logic [31:0] word_zero;
        logic [31:0] word_one;
    } t_tea_in;

    typedef struct packed {
        logic [31:0] out_word_zero;
        logic [31:0] out_word_one;
    } t_tea_out;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

    // running sum of encryption round r (zero based)
    function automatic logic [31:0] tea_enc_sum(input int unsigned round);
        logic [63:0] p;
        p = 64'(TEA_DELTA) * 64'(round + 1);
        return p[31:0];
    endfunction

    // running sum of decryption round r (zero based)
    function automatic logic [31:0] tea_dec_sum(
        input int unsigned rounds,
        input int unsigned round
    );
        logic [63:0] p;
        p = 64'(TEA_DELTA) * 64'(rounds - round);
        return p[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tea_half_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tea_half_round
// One registered half round: updates one word of the block with the mix of
// the other, adding for encryption and subtracting for decryption.
// ----------------------------------------------------------------------------
module tea_half_round
    import tea_pkg::*;
#(
    parameter logic [31:0] ENC_SUM    = TEA_DELTA,
    parameter logic [31:0] DEC_SUM    = TEA_DELTA,
    parameter bit          FIRST_HALF = 1'b1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_tea_in     i_data,
    input  wire logic [31:0] i_key0,
    input  wire logic [31:0] i_key1,
    input  wire logic [31:0] i_key2,
    input  wire logic [31:0] i_key3,
    output logic             o_valid,
    output t_tea_in          o_data
);

    logic        r_valid;
    t_tea_in     r_data;
    t_tea_in     n_data;
    logic        upd_zero;
    logic        is_dec;
    logic [31:0] x;
    logic [31:0] sum;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] m;
    logic [31:0] tgt;
    logic [31:0] res;

    always_comb begin
        is_dec   = (t_op'(i_data.req_type) == OP_DECRYPT);
        // encrypt updates word zero first, decrypt updates word one first
        upd_zero = is_dec ^ FIRST_HALF;
        sum      = is_dec ? DEC_SUM : ENC_SUM;
        x        = upd_zero ? i_data.word_one  : i_data.word_zero;
        tgt      = upd_zero ? i_data.word_zero : i_data.word_one;
        ka       = upd_zero ? i_key0 : i_key2;
        kb       = upd_zero ? i_key1 : i_key3;
        m        = tea_mix(x, sum, ka, kb);
        res      = is_dec ? (tgt - m) : (tgt + m);
        n_data   = i_data;
        if (upd_zero) begin
            n_data.word_zero = res;
        end else begin
            n_data.word_one = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/tea_block_cipher_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tea_block_cipher_top
// TEA block cipher, fully pipelined, one 64-bit block per clock.
// ----------------------------------------------------------------------------
// usage:
//   load the 128-bit key through i_cfg_we / i_cfg_idx / i_cfg_data, one
//   32-bit key word per write, while no block is in flight
//   a word is taken at every clock edge where i_start is high and o_busy
//   is low; o_busy is always low, so a new block may enter every cycle
//   i_word.req_type selects encrypt (0) or decrypt (1) per block
//   each round is cut into two register stages (one per half), and a block
//   passes through all of them in order before it leaves
//   the result sits on o_result for one cycle, marked by o_done; blocks
//   come out in the order they went in and the receiver cannot stall
//   throughput: one block per cycle, set by one half round per stage
//   reset clears the key words to zero and drops every block in flight
// ----------------------------------------------------------------------------
module tea_block_cipher_top
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire t_tea_in              i_word,
    output logic                      o_done,
    output t_tea_out                  o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [KEY_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int unsigned STAGES = 2 * ROUNDS;

    logic [31:0] r_key0;
    logic [31:0] r_key1;
    logic [31:0] r_key2;
    logic [31:0] r_key3;

    logic        stg_valid [0:STAGES];
    t_tea_in     stg_data  [0:STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_we) begin
            case (t_key_idx'(i_cfg_idx))
                KEY_WORD_0: r_key0 <= i_cfg_data;
                KEY_WORD_1: r_key1 <= i_cfg_data;
                KEY_WORD_2: r_key2 <= i_cfg_data;
                KEY_WORD_3: r_key3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy       = 1'b0;
    assign stg_valid[0] = i_start & ~o_busy;
    assign stg_data[0]  = i_word;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        tea_half_round #(
            .ENC_SUM    (tea_enc_sum(s / 2)),
            .DEC_SUM    (tea_dec_sum(ROUNDS, s / 2)),
            .FIRST_HALF ((s % 2) == 0)
        ) u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[s]),
            .i_data  (stg_data[s]),
            .i_key0  (r_key0),
            .i_key1  (r_key1),
            .i_key2  (r_key2),
            .i_key3  (r_key3),
            .o_valid (stg_valid[s+1]),
            .o_data  (stg_data[s+1])
        );
    end

    assign o_done                 = stg_valid[STAGES];
    assign o_result.out_word_zero = stg_data[STAGES].word_zero;
    assign o_result.out_word_one  = stg_data[STAGES].word_one;

endmodule
`default_nettype wire

// ===== tb/tea_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// tea_cipher_checker
// Watches the block and key channels of the TEA cipher, works out each
// enciphered or deciphered block from its own copy of the key words and
// compares it, field by field and in order, with the block the cipher emits.
// ----------------------------------------------------------------------------
module tea_cipher_checker
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_tea_in              i_word,
    input  logic                 i_done,
    input  t_tea_out             i_result,
    input  logic                 i_cfg_we,
    input  logic [KEY_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] key_words [4];
    t_tea_out    expected_blocks [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] half_round(
        input logic [31:0] x,
        input logic [31:0] sum,
        input logic [31:0] k_left,
        input logic [31:0] k_right
    );
        logic [31:0] left_term;
        logic [31:0] right_term;
        left_term  = {x[27:0], 4'b0000} + k_left;
        right_term = {5'b00000, x[31:5]} + k_right;
        return left_term ^ (x + sum) ^ right_term;
    endfunction

    function automatic t_tea_out cipher_block(input t_tea_in blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        t_tea_out    res;
        v0 = blk.word_zero;
        v1 = blk.word_one;
        if (t_op'(blk.req_type) == OP_ENCRYPT) begin
            sum = '0;
            for (int r = 0; r < int'(ROUNDS); r++) begin
                sum = sum + TEA_DELTA;
                v0  = v0 + half_round(v1, sum, key_words[0], key_words[1]);
                v1  = v1 + half_round(v0, sum, key_words[2], key_words[3]);
            end
        end else begin
            // start sum is delta times the round count, wrapped to 32 bits
            sum = TEA_DELTA * 32'(ROUNDS);
            for (int r = 0; r < int'(ROUNDS); r++) begin
                v1  = v1 - half_round(v0, sum, key_words[2], key_words[3]);
                v0  = v0 - half_round(v1, sum, key_words[0], key_words[1]);
                sum = sum - TEA_DELTA;
            end
        end
        res.out_word_zero = v0;
        res.out_word_one  = v1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_tea_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) key_words[k] = '0;
            expected_blocks.delete();
        end else begin
            if (i_done) begin
                if (expected_blocks.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected word %h %h", $realtime,
                                 i_result.out_word_zero, i_result.out_word_one);
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_result.out_word_zero !== want.out_word_zero ||
                        i_result.out_word_one  !== want.out_word_one) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch expected %h %h actual %h %h",
                                     $realtime, want.out_word_zero,
                                     want.out_word_one, i_result.out_word_zero,
                                     i_result.out_word_one);
                    end
                end
            end
            if (i_start && !i_busy)
                expected_blocks.push_back(cipher_block(i_word));
            if (i_cfg_we) begin
                case (t_key_idx'(i_cfg_idx))
                    KEY_WORD_0: key_words[0] = i_cfg_data;
                    KEY_WORD_1: key_words[1] = i_cfg_data;
                    KEY_WORD_2: key_words[2] = i_cfg_data;
                    KEY_WORD_3: key_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_blocks.size();
    end

endmodule

// ===== tb/tb_tea_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// tb_tea_block_cipher_top
// Drives the TEA cipher with directed and random blocks of both operations
// under several key settings, with random sender gaps, and reports the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_tea_block_cipher_top
    import tea_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROUNDS = TEA_ROUNDS;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    t_tea_in              word_in;
    logic                 done;
    t_tea_out             result;
    logic                 cfg_we;
    logic [KEY_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_data;
    int                   fail_count;
    int                   pending;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tea_block_cipher_top #(.ROUNDS(ROUNDS)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_word     (word_in),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tea_cipher_checker #(.ROUNDS(ROUNDS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_word       (word_in),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // returns before the accepting edge; the next call or idle moves past it
    task automatic send_block(input t_op op, input logic [31:0] w0, input logic [31:0] w1);
        @(negedge clk);
        start             = 1'b1;
        word_in.req_type  = op;
        word_in.word_zero = w0;
        word_in.word_one  = w1;
        while (busy) @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_key(input t_key_idx idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // mostly random words, with zero, all ones and one-hot mixed in
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_extremes();
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic send_random(input int n, input bit allow_gaps);
        bit quiet;
        quiet = 1'b0;
        for (int i = 0; i < n; i++) begin
            // stretches of back-to-back words between gappy ones
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            send_block(t_op'($urandom_range(0, 1)), pick_word(), pick_word());
            if (allow_gaps && !quiet && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 10));
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        start    = 1'b0;
        word_in  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = KEY_WORD_0;
        cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset keys are all zero: known vector, its inverse, bit extremes
        send_extremes();
        send_block(OP_DECRYPT, 32'h41EA_3A0A, 32'h94BA_A940);
        send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        send_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_block(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_random(200, 1'b1);

        for (int phase = 1; phase <= 4; phase++) begin
            wait_drained();
            idle_cycles(2 * ROUNDS + 4);
            for (int k = 0; k < 4; k++) begin
                case (phase)
                    1:       write_key(t_key_idx'(k), 32'hFFFF_FFFF);
                    2:       write_key(t_key_idx'(k), (k % 2) ? 32'hFFFF_FFFF : 32'h0);
                    default: write_key(t_key_idx'(k), $urandom());
                endcase
            end
            if (phase <= 2)
                send_extremes();
            if (phase == 2) begin
                send_random(110, 1'b1);
                wait_drained();
                send_random(110, 1'b1);
            end else if (phase == 4) begin
                send_random(70, 1'b1);
                send_random(150, 1'b0);
            end else begin
                send_random(220, 1'b1);
            end
        end

        wait_drained();
        idle_cycles(2 * ROUNDS + 8);
        if (fail_count == 0)
            $display("tb_tea_block_cipher_top: PASS");
        else
            $display("tb_tea_block_cipher_top: FAIL");
        $finish;
    end

    initial begin
        #400_000;
        $display("tb_tea_block_cipher_top: FAIL");
        $finish;
    end

endmodule
